// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define AST_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, reset masked.
`define AST_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/psp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and codes of the per-source policer.
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam logic [1:0] STAT_EXIST = 2'd0;
    localparam logic [1:0] STAT_NEW   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_SWEEP = 2'd3;

    localparam logic [1:0] CFG_BURST = 2'd0;
    localparam logic [1:0] CFG_RATE  = 2'd1;
    localparam logic [1:0] CFG_IDLE  = 2'd2;

    localparam logic [35:0] MICRO_PER_TOKEN = 36'd1000000;
    localparam logic [19:0] MICRO_PER_TOKEN_20 = 20'd1000000;

    typedef struct packed {
        logic        sweep;
        logic [31:0] addr;
        logic [47:0] now;
    } t_cmd;

    typedef struct packed {
        logic [35:0] cap;
        logic [19:0] rate;
        logic [31:0] idle;
    } t_cfg;

endpackage

// File: rtl/psp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_front
// Input stage: take a word, split it into a command and hand it on.
// ----------------------------------------------------------------------------
module psp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,  // source_addr[31:0], now_us[79:32]
    input  logic          s_axis_tuser,  // op
    output logic          o_push_valid,
    output psp_pkg::t_cmd o_push_cmd,
    input  logic          i_push_ready
);
    logic          r_full;
    psp_pkg::t_cmd r_cmd;

    assign s_axis_tready = !r_full || i_push_ready;
    assign o_push_valid  = r_full;
    assign o_push_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_full <= 1'b1;
        end else if (i_push_ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd.sweep <= s_axis_tuser;
            r_cmd.addr  <= s_axis_tdata[31:0];
            r_cmd.now   <= s_axis_tdata[79:32];
        end
    end
endmodule

// File: rtl/psp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module psp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psp_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output psp_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    psp_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_wr, w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= i_cmd;
    end
endmodule

// File: rtl/psp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_back
// Bucket table and sequencer: look up, refill, consume, age out.
// ----------------------------------------------------------------------------
module psp_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  psp_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  psp_pkg::t_cfg i_cfg,
    output logic          o_res_valid,
    output logic [7:0]    o_res_data,
    output logic [1:0]    o_res_user,
    input  logic          i_res_ready
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;
    localparam logic [2:0] S_SWEEP = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]  r_state;
    psp_pkg::t_cmd r_cmd;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0] r_key [TABLE_ENTRIES];
    logic [83:0] r_mem [TABLE_ENTRIES];  // tokens[83:48], last refill[47:0]
    logic [83:0] r_rd;
    logic [IW-1:0] r_slot;
    logic        r_hit, r_full, r_new;
    logic [35:0] r_tok;
    logic [47:0] r_last;
    logic        r_pos, r_sat;
    logic [55:0] r_prod;
    logic [CW-1:0] r_cnt, r_rm;
    logic        r_pend;
    logic [IW-1:0] r_pidx;
    logic        r_allow;
    logic [1:0]  r_stat;
    logic        r_ovalid;
    logic [7:0]  r_odata;
    logic [1:0]  r_ouser;

    logic [IW-1:0] w_hit_idx, w_free_idx, w_rd_addr;
    logic        w_any_hit, w_any_free;
    logic [35:0] w_tok, w_nt, w_fin;
    logic [47:0] w_last, w_el, w_sw_last, w_idle;
    logic [56:0] w_sum, w_add;
    logic        w_expire, w_out_free, w_allow, w_emit;
    logic [6:0]  w_rm_sat;

    assign w_out_free = !r_ovalid || i_res_ready;
    assign w_emit     = w_out_free && (r_state inside {S_WB, S_EMIT});
    assign o_pop      = (r_state == S_IDLE) && i_cmd_valid;

    // Match and first free slot over the key row.
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        w_any_hit  = 1'b0;
        w_any_free = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == i_cmd.addr) begin
                w_hit_idx = IW'(i);
                w_any_hit = 1'b1;
            end
            if (!r_valid[i]) begin
                w_free_idx = IW'(i);
                w_any_free = 1'b1;
            end
        end
    end

    assign w_rd_addr = (r_state == S_SWEEP) ? r_cnt[IW-1:0] : r_slot;

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_rd_addr];
        if (r_state == S_WB && w_out_free) r_mem[r_slot] <= {w_fin, r_last};
    end

    // Refill datapath.
    assign w_tok  = r_new ? i_cfg.cap : r_rd[83:48];
    assign w_last = r_new ? r_cmd.now : r_rd[47:0];
    assign w_el   = r_cmd.now - w_last;
    assign w_add  = r_sat ? {21'd0, i_cfg.cap} : {1'b0, r_prod};
    assign w_sum  = {21'd0, r_tok} + w_add;
    assign w_nt   = (w_sum < {21'd0, i_cfg.cap}) ? w_sum[35:0] : i_cfg.cap;
    assign w_allow = (r_tok >= psp_pkg::MICRO_PER_TOKEN);
    assign w_fin  = w_allow ? r_tok - psp_pkg::MICRO_PER_TOKEN : r_tok;

    // Sweep datapath.
    assign w_sw_last = r_rd[47:0];
    assign w_idle    = (r_cmd.now > w_sw_last) ? r_cmd.now - w_sw_last : 48'd0;
    assign w_expire  = r_pend && r_valid[r_pidx] && (w_idle >= {16'd0, i_cfg.idle});
    assign w_rm_sat  = (r_rm > CW'(127)) ? 7'd127 : 7'(r_rm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= i_cmd.sweep ? S_SWEEP : S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= (!r_hit && r_full) ? S_EMIT : S_CALC;
                end
                S_CALC: r_state <= S_FIN;
                S_FIN:  r_state <= S_WB;
                S_WB: begin
                    if (w_out_free) begin
                        if (r_new) r_valid[r_slot] <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    r_pend <= (r_cnt < CW'(TABLE_ENTRIES));
                    if (w_expire) r_valid[r_pidx] <= 1'b0;
                    if (r_cnt == CW'(TABLE_ENTRIES) && !r_pend) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_hit  <= w_any_hit;
                r_full <= !w_any_free;
                r_new  <= !w_any_hit;
                r_slot <= w_any_hit ? w_hit_idx : w_free_idx;
                r_cnt  <= '0;
                r_rm   <= '0;
            end
            S_LOOK: begin
                r_allow <= 1'b0;
                r_stat  <= psp_pkg::STAT_FULL;
            end
            S_CALC: begin
                r_tok  <= w_tok;
                r_last <= w_last;
                r_pos  <= (r_cmd.now > w_last) && (i_cfg.rate != 20'd0);
                r_sat  <= (w_el >= {12'd0, i_cfg.cap});
                r_prod <= 56'(w_el[35:0]) * 56'(i_cfg.rate);
            end
            S_FIN: begin
                if (r_pos) begin
                    r_tok  <= w_nt;
                    r_last <= r_cmd.now;
                end
            end
            S_WB: begin
                r_allow <= w_allow;
                r_stat  <= r_new ? psp_pkg::STAT_NEW : psp_pkg::STAT_EXIST;
                if (w_out_free) begin
                    r_odata <= {7'd0, w_allow};
                    r_ouser <= r_new ? psp_pkg::STAT_NEW : psp_pkg::STAT_EXIST;
                end
            end
            S_SWEEP: begin
                if (r_cnt < CW'(TABLE_ENTRIES)) r_cnt <= r_cnt + 1'b1;
                r_pidx <= r_cnt[IW-1:0];
                if (w_expire) r_rm <= r_rm + 1'b1;
                r_allow <= 1'b0;
                r_stat  <= psp_pkg::STAT_SWEEP;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_odata <= {(r_stat == psp_pkg::STAT_SWEEP) ? w_rm_sat : 7'd0, r_allow};
                    r_ouser <= r_stat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB && w_out_free && r_new) r_key[r_slot] <= r_cmd.addr;
    end

    assign o_res_valid = r_ovalid;
    assign o_res_data  = r_odata;
    assign o_res_user  = r_ouser;
endmodule

// File: rtl/per_source_token_bucket_policer.sv
`timescale 1ns / 1ps
// Path: a packet check passes the front register, the queue, then the back-end states
//   IDLE, LOOK, CALC, FIN and WB (LOOK to EMIT on a full table); a sweep: SWEEP, EMIT.
// Flow: the back end works on one command at a time, with its refill sequence on the single
//   table memory port, and takes the next only back in IDLE; a sweep holds it for every entry.
// Reset: synchronous, active low; empties the table (valid bits only, no clearing
//   pass) and loads burst 100, rate 10 and idle limit 61000000 us.
// ----------------------------------------------------------------------------
// per_source_token_bucket_policer
// Token bucket policer keyed by IPv4 source address, with idle aging.
// ----------------------------------------------------------------------------
module per_source_token_bucket_policer #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // source_addr[31:0], now_us[79:32]
    input  logic        s_axis_tuser,  // op: check or sweep
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // allowed[0], removed_count[7:1]
    output logic [1:0]  m_axis_tuser,  // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    // Configuration registers; capacity in micro-tokens is kept precomputed.
    logic [15:0] r_burst;
    logic [19:0] r_rate;
    logic [31:0] r_idle;
    logic [35:0] r_cap;
    psp_pkg::t_cfg w_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= 16'd100;
            r_rate  <= 20'd10;
            r_idle  <= 32'd61000000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psp_pkg::CFG_BURST: r_burst <= i_cfg_data[15:0];
                psp_pkg::CFG_RATE:  r_rate  <= i_cfg_data[19:0];
                psp_pkg::CFG_IDLE:  r_idle  <= i_cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Burst times one million; refresh every cycle, settles long before use.
    always_ff @(posedge i_clk) begin
        r_cap <= 36'(r_burst) * 36'(psp_pkg::MICRO_PER_TOKEN_20);
    end

    assign w_cfg.cap  = r_cap;
    assign w_cfg.rate = r_rate;
    assign w_cfg.idle = r_idle;

    // Front end: hold the incoming word as a command.
    logic          w_push_valid, w_push_ready;
    psp_pkg::t_cmd w_push_cmd;

    psp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (w_push_valid),
        .o_push_cmd    (w_push_cmd),
        .i_push_ready  (w_push_ready)
    );

    // Queue decouples intake from the table sequencer.
    logic          w_cmd_valid, w_pop;
    psp_pkg::t_cmd w_cmd;

    psp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push_valid),
        .i_cmd   (w_push_cmd),
        .o_ready (w_push_ready),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd),
        .i_pop   (w_pop)
    );

    // Back end: lookup, refill, consume, age out; owns the output register.
    psp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_res_valid (m_axis_tvalid),
        .o_res_data  (m_axis_tdata),
        .o_res_user  (m_axis_tuser),
        .i_res_ready (m_axis_tready)
    );
endmodule

// File: rtl/psp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_checker
// Port-level checks of the policer result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);
    // Hold a stalled result word.
    `AST_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // A sweep never passes a packet.
    `AST_SAME(a_sweep_deny, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == psp_pkg::STAT_SWEEP, !m_axis_tdata[0])
    // A full table denies and frees nothing.
    `AST_SAME(a_full_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == psp_pkg::STAT_FULL, m_axis_tdata == 8'd0)
    // Only a sweep reports freed entries.
    `AST_SAME(a_count_sweep, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != psp_pkg::STAT_SWEEP, m_axis_tdata[7:1] == 7'd0)
endmodule

bind per_source_token_bucket_policer psp_checker u_psp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: sim/per_source_token_bucket_policer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_token_bucket_policer_tb
// Self-checking bench for the per-source token bucket policer.
// Keeps its own bucket table, predicts allow/status/freed count for every
// accepted word, and checks each output word against the oldest prediction.
// Runs a directed opening, then random phases with varied settings and idling.
// ----------------------------------------------------------------------------
module per_source_token_bucket_policer_tb;

    localparam int   ENTRIES    = 64;
    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_SWEEP   = 1'b1;
    localparam longint unsigned MICRO = 64'd1000000;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   SETTLE      = 100;   // covers a full sweep of the table

    typedef struct {
        logic        op;
        logic [31:0] addr;
        logic [47:0] now;
    } t_pkt;

    typedef struct {
        logic       allowed;
        logic [1:0] status;
        logic [6:0] freed;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // source_addr[31:0], now_us[79:32]
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // allowed[0], removed_count[7:1]
    logic [1:0]  m_axis_tuser;        // status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    per_source_token_bucket_policer #(.TABLE_ENTRIES(ENTRIES)) dut (.*);

    always #10 i_clk = ~i_clk;

    // Shadow table and settings
    bit              tbl_valid [ENTRIES];
    logic [31:0]     tbl_key   [ENTRIES];
    longint unsigned tbl_tok   [ENTRIES];
    longint unsigned tbl_last  [ENTRIES];
    longint unsigned burst = 100, rate = 10, idle_limit = 61000000;

    t_pkt     pending_pkts[$];
    t_verdict verdicts_due[$];
    int       send_idle_pct = 0, recv_stall_pct = 0;
    int       mismatches = 0, words_in = 0, words_out = 0, sweeps_seen = 0;
    int       denied_seen = 0, full_seen = 0, freed_total = 0;
    int       cycles = 0;
    logic [47:0] clock_us = '0;

    // Work out the verdict of one packet word and advance the shadow table
    function automatic t_verdict police(t_pkt p);
        t_verdict v;
        int slot, free_slot, n;
        longint unsigned cap, now, elapsed, add, sum, idle;
        v = '{1'b0, psp_pkg::STAT_EXIST, 7'd0};
        now = p.now;
        cap = burst * MICRO;
        if (p.op == OP_SWEEP) begin
            n = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    idle = now > tbl_last[i] ? now - tbl_last[i] : 0;
                    if (idle >= idle_limit) begin
                        tbl_valid[i] = 0;
                        n++;
                    end
                end
            end
            v.status = psp_pkg::STAT_SWEEP;
            v.freed = n > 127 ? 7'd127 : 7'(n);
            return v;
        end
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (slot < 0 && tbl_key[i] == p.addr) slot = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (slot < 0) begin
            if (free_slot < 0) begin
                v.status = psp_pkg::STAT_FULL;
                return v;
            end
            slot = free_slot;
            tbl_valid[slot] = 1;
            tbl_key[slot] = p.addr;
            tbl_tok[slot] = cap;
            tbl_last[slot] = now;
            v.status = psp_pkg::STAT_NEW;
        end
        // Refill only on a positive elapsed time and non-zero rate
        if (now > tbl_last[slot] && rate != 0) begin
            elapsed = now - tbl_last[slot];
            add = elapsed >= cap ? cap : elapsed * rate;
            sum = tbl_tok[slot] + add;
            tbl_tok[slot] = sum < cap ? sum : cap;
            tbl_last[slot] = now;
        end
        if (tbl_tok[slot] >= MICRO) begin
            tbl_tok[slot] -= MICRO;
            v.allowed = 1'b1;
        end
        return v;
    endfunction

    // Driver: predict on acceptance, hold while stalled, idle at random
    always @(posedge i_clk) begin
        t_pkt p;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                p.op = s_axis_tuser;
                p.addr = s_axis_tdata[31:0];
                p.now = s_axis_tdata[79:32];
                verdicts_due.insert(verdicts_due.size(), police(p));
                words_in++;
            end
            if (pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                p = pending_pkts.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= p.op;
                s_axis_tdata <= {p.now, p.addr};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each output word with the oldest verdict
    always @(posedge i_clk) begin
        t_verdict e;
        cycles++;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
            if (m_axis_tvalid && m_axis_tready) begin
                words_out++;
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected word tdata=%h tuser=%0d",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    e = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== e.allowed || m_axis_tuser !== e.status ||
                        m_axis_tdata[7:1] !== e.freed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: word %0d exp allow=%0d st=%0d freed=%0d, %s%0d%s%0d%s%0d",
                                     words_out, e.allowed, e.status, e.freed,
                                     "got allow=", m_axis_tdata[0], " st=", m_axis_tuser,
                                     " freed=", m_axis_tdata[7:1]);
                    end
                    if (e.status == psp_pkg::STAT_SWEEP) begin
                        sweeps_seen++;
                        freed_total += e.freed;
                    end
                    if (e.status == psp_pkg::STAT_FULL) full_seen++;
                    if (e.status != psp_pkg::STAT_SWEEP && !e.allowed) denied_seen++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_pkt(logic op, logic [31:0] addr, logic [47:0] now);
        t_pkt p;
        p.op = op;
        p.addr = addr;
        p.now = now;
        pending_pkts.insert(pending_pkts.size(), p);
    endtask

    // Hold until everything sent has come back, then let a sweep finish
    task automatic drain();
        while (pending_pkts.size() > 0 || s_axis_tvalid || verdicts_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            psp_pkg::CFG_BURST: burst = val[15:0];
            psp_pkg::CFG_RATE:  rate = val[19:0];
            default:            idle_limit = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] b, logic [31:0] r, logic [31:0] il);
        write_reg(psp_pkg::CFG_BURST, b);
        write_reg(psp_pkg::CFG_RATE, r);
        write_reg(psp_pkg::CFG_IDLE, il);
    endtask

    initial begin
        logic [31:0] pool [100];
        int pool_n, pick;
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extremes of address and time
        queue_pkt(OP_CHECK, 32'h0, 48'd0);
        queue_pkt(OP_CHECK, 32'hFFFF_FFFF, 48'd5);
        queue_pkt(OP_CHECK, 32'h0, 48'd10);
        queue_pkt(OP_SWEEP, 32'hFFFF_FFFF, 48'd20);
        queue_pkt(OP_CHECK, 32'h0, 48'd1000000);
        queue_pkt(OP_CHECK, 32'h0, 48'd500);          // time running backward
        queue_pkt(OP_SWEEP, 32'h0, 48'd600);          // backward time counts as no idle
        queue_pkt(OP_SWEEP, 32'h0, 48'hFFFF_FFFF_FFFF);
        queue_pkt(OP_CHECK, 32'hA5A5_5A5A, 48'hFFFF_FFFF_FFFF);
        drain();
        // One token, no refill, instant aging
        set_regs(32'd1, 32'd0, 32'd0);
        queue_pkt(OP_CHECK, 32'h1234_5678, 48'd100);
        queue_pkt(OP_CHECK, 32'h1234_5678, 48'd900000);
        queue_pkt(OP_SWEEP, 32'h0, 48'd900000);
        drain();
        // Empty buckets from a zero burst
        write_reg(psp_pkg::CFG_BURST, 32'd0);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd50);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd60);
        drain();
        // Largest burst and a rate of 1000000, then lower the burst under the stored tokens
        set_regs(32'd65535, 32'd1000000, 32'hFFFF_FFFF);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd70);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd80);
        drain();
        write_reg(psp_pkg::CFG_BURST, 32'd2);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd81);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd82);
        queue_pkt(OP_CHECK, 32'h0BAD_F00D, 48'd83);
        queue_pkt(OP_SWEEP, 32'h0, 48'd84);
        drain();

        // Random phases: vary settings and idling
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            case (ph)
                0: set_regs(32'd1, 32'd1, 32'd0);
                1: set_regs(32'd65535, 32'd1000000, 32'hFFFF_FFFF);
                2: set_regs(32'd3, 32'd0, 32'd50000);
                default: set_regs($urandom_range(1, 6), $urandom_range(0, 1000000),
                                  $urandom_range(0, 400000));
            endcase
            pool_n = $urandom_range(40, 100);
            for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
            clock_us = 48'({8'($urandom_range(0, 255)), 32'($urandom)});
            for (int k = 0; k < 160; k++) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    clock_us = clock_us - $urandom_range(0, 5000);
                else if (pick < 6)
                    clock_us = clock_us + {$urandom, 4'h0};
                else
                    clock_us = clock_us + $urandom_range(0, 20000);
                pick = $urandom_range(99);
                if (pick < 4)
                    queue_pkt(OP_SWEEP, $urandom, clock_us);
                else if (pick < 14)
                    queue_pkt(OP_CHECK, $urandom, clock_us);
                else
                    queue_pkt(OP_CHECK, pool[$urandom_range(pool_n - 1)], clock_us);
            end
            drain();
        end

        $display("Covered %0d words in, %0d out: %0d sweeps freeing %0d entries,",
                 words_in, words_out, sweeps_seen, freed_total);
        $display("%0d denied checks, %0d table-full refusals, %0d mismatches",
                 denied_seen, full_seen, mismatches);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
